@@ hw/rtl/gprd_pkg.sv @@
// gprd_pkg: key masks, action codes, turbo divide constants and the stage type
// shared by the gamepad report decoder modules
// no dependencies
package gprd_pkg;

  // pressed-word key masks (after inversion of the raw active-low bytes)
  localparam logic [15:0] KEY_UP       = 16'h0001;
  localparam logic [15:0] KEY_LEFT     = 16'h0002;
  localparam logic [15:0] KEY_X        = 16'h0008;
  localparam logic [15:0] KEY_A        = 16'h0010;
  localparam logic [15:0] KEY_Y        = 16'h0020;
  localparam logic [15:0] KEY_B        = 16'h0040;
  localparam logic [15:0] KEY_R        = 16'h0200;
  localparam logic [15:0] KEY_START    = 16'h0400;
  localparam logic [15:0] KEY_SELECT   = 16'h1000;
  localparam logic [15:0] KEY_L        = 16'h2000;
  localparam logic [15:0] KEY_DOWN     = 16'h4000;
  localparam logic [15:0] KEY_RIGHT    = 16'h8000;
  localparam logic [15:0] KEY_CHORD    = KEY_L | KEY_R | KEY_START | KEY_SELECT;
  localparam logic [15:0] KEY_SHOULDER = KEY_L | KEY_R;
  localparam logic [15:0] KEY_STSEL    = KEY_START | KEY_SELECT;

  // command codes
  localparam logic CMD_REPORT  = 1'b0;
  localparam logic CMD_FAILURE = 1'b1;

  // action bits
  localparam logic [4:0] ACT_SETTINGS = 5'h01;
  localparam logic [4:0] ACT_DIM      = 5'h02;
  localparam logic [4:0] ACT_BRIGHTEN = 5'h04;
  localparam logic [4:0] ACT_LOAD     = 5'h08;
  localparam logic [4:0] ACT_SAVE     = 5'h10;

  // floor(d / 50) = (d * TURBO_MAGIC) >> 36 for any 32-bit d; bit 36 is the phase
  localparam logic [31:0] TURBO_MAGIC     = 32'h51EB_851F;
  localparam int          TURBO_PHASE_BIT = 36;

  // game/navigation bit positions
  localparam int BTN_A      = 4;
  localparam int BTN_B      = 5;
  localparam int BTN_START  = 6;
  localparam int BTN_SELECT = 7;

  // decode stage result, carried to the turbo stage
  typedef struct packed {
    logic [7:0]  game_base;  // game buttons without turbo contribution
    logic [5:0]  nav;
    logic [4:0]  act;
    logic        connected;
    logic        rejected;
    logic        turbo_a_en; // X held, A follows turbo phase
    logic        turbo_b_en; // Y held, B follows turbo phase
    logic [31:0] elapsed_a;
    logic [31:0] elapsed_b;
  } gprd_mid_t;

endpackage

@@ hw/rtl/gprd_decode.sv @@
// gprd_decode: button decode, edge detect, chord/shortcut logic and state registers
// depends on gprd_pkg
module gprd_decode
  import gprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,       // item leaves the input register this cycle
  input  logic        cmd,
  input  logic [7:0]  report_hi,
  input  logic [7:0]  report_lo,
  input  logic [31:0] now_ms,
  output gprd_mid_t   mid
);

  logic [15:0] prev_pressed_r, prev_pressed_nxt;
  logic        chord_active_r, chord_active_nxt;
  logic        sel_consumed_r, sel_consumed_nxt;
  logic [31:0] turbo_a_start_r, turbo_a_start_nxt;
  logic [31:0] turbo_b_start_r, turbo_b_start_nxt;
  logic        link_up_r, link_up_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pressed_r  <= '0;
      chord_active_r  <= 1'b0;
      sel_consumed_r  <= 1'b0;
      turbo_a_start_r <= '0;
      turbo_b_start_r <= '0;
      link_up_r       <= 1'b0;
    end else if (take) begin
      prev_pressed_r  <= prev_pressed_nxt;
      chord_active_r  <= chord_active_nxt;
      sel_consumed_r  <= sel_consumed_nxt;
      turbo_a_start_r <= turbo_a_start_nxt;
      turbo_b_start_r <= turbo_b_start_nxt;
      link_up_r       <= link_up_nxt;
    end
  end

  always_comb begin
    logic [15:0] pressed;
    logic [15:0] rising;
    logic [15:0] shoulders;
    logic        chord_now;
    logic [5:0]  dir;

    pressed   = ~{report_hi, report_lo};
    rising    = pressed & ~prev_pressed_r;
    shoulders = pressed & KEY_SHOULDER;
    dir       = '0;
    chord_now = 1'b0;

    prev_pressed_nxt  = prev_pressed_r;
    chord_active_nxt  = chord_active_r;
    sel_consumed_nxt  = sel_consumed_r;
    turbo_a_start_nxt = turbo_a_start_r;
    turbo_b_start_nxt = turbo_b_start_r;
    link_up_nxt       = link_up_r;
    mid               = '0;

    if (cmd == CMD_FAILURE || !report_hi[0]) begin
      // bus failure or malformed report: drop link, keep turbo start times
      link_up_nxt      = 1'b0;
      chord_active_nxt = 1'b0;
      sel_consumed_nxt = 1'b0;
      prev_pressed_nxt = '0;
      mid.rejected     = 1'b1;
    end else begin
      link_up_nxt      = 1'b1;
      mid.connected    = 1'b1;
      prev_pressed_nxt = pressed;
      chord_now        = chord_active_r || ((pressed & KEY_CHORD) == KEY_CHORD);
      if (!chord_active_r && ((pressed & KEY_CHORD) == KEY_CHORD)) begin
        mid.act = ACT_SETTINGS;
      end
      if (chord_now) begin
        // chord swallowed until all four keys released
        sel_consumed_nxt = 1'b1;
        chord_active_nxt = ((pressed & KEY_CHORD) != '0);
      end else begin
        if ((rising & KEY_X) != '0) turbo_a_start_nxt = now_ms;
        if ((rising & KEY_Y) != '0) turbo_b_start_nxt = now_ms;

        if ((pressed & KEY_SELECT) == '0) sel_consumed_nxt = 1'b0;
        if ((pressed & KEY_STSEL) == KEY_STSEL) begin
          // shoulders held back while the chord is being formed
        end else if ((pressed & KEY_SELECT) != '0 && shoulders != '0) begin
          sel_consumed_nxt = 1'b1;
          if (shoulders == KEY_L && (rising & KEY_L) != '0) mid.act = mid.act | ACT_DIM;
          if (shoulders == KEY_R && (rising & KEY_R) != '0) mid.act = mid.act | ACT_BRIGHTEN;
        end else if ((pressed & KEY_SELECT) == '0) begin
          if (shoulders == KEY_L && (rising & KEY_L) != '0) mid.act = mid.act | ACT_LOAD;
          if (shoulders == KEY_R && (rising & KEY_R) != '0) mid.act = mid.act | ACT_SAVE;
        end

        dir[0]     = (pressed & KEY_UP) != '0;
        dir[1]     = (pressed & KEY_DOWN) != '0;
        dir[2]     = (pressed & KEY_LEFT) != '0;
        dir[3]     = (pressed & KEY_RIGHT) != '0;
        dir[BTN_A] = (pressed & KEY_A) != '0;
        dir[BTN_B] = (pressed & KEY_B) != '0;
        mid.nav    = dir;

        mid.game_base[5:0]        = dir;
        mid.game_base[BTN_START]  = (pressed & KEY_START) != '0;
        mid.game_base[BTN_SELECT] = ((pressed & KEY_SELECT) != '0) && !sel_consumed_nxt;

        mid.turbo_a_en = (pressed & KEY_X) != '0;
        mid.turbo_b_en = (pressed & KEY_Y) != '0;
        mid.elapsed_a  = now_ms - turbo_a_start_nxt;
        mid.elapsed_b  = now_ms - turbo_b_start_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/gprd_turbo.sv @@
// gprd_turbo: turbo phase of one elapsed time, floor(elapsed / 50) odd or even
// by reciprocal multiply; depends on gprd_pkg
module gprd_turbo
  import gprd_pkg::*;
(
  input  logic [31:0] elapsed,
  output logic        phase_on
);

  logic [63:0] prod;

  assign prod     = {32'd0, elapsed} * {32'd0, TURBO_MAGIC};
  // even half-period count means on
  assign phase_on = !prod[TURBO_PHASE_BIT];

endmodule

@@ hw/rtl/gamepad_report_decoder_turbo.sv @@
// gamepad_report_decoder_turbo: controller report decoder with turbo and chords
// an accepted item passes through the input, decode and result registers to out_tvalid
// throughput: one item per cycle, sustained while out_tready stays high
// reset (rst_n low, synchronous): pipeline emptied, all decoder state cleared to zero
// depends on gprd_pkg, gprd_decode, gprd_turbo
module gamepad_report_decoder_turbo
  import gprd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // report_hi[7:0], report_lo[15:8], now_ms[47:16]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // game_buttons[7:0], navigation_buttons[13:8],
                                  // actions[18:14], connected[19], report_rejected[20],
                                  // zero fill [23:21]
);

  // stage valids and advance strobes; stall ripples back from out_tready
  logic      in_vld_r, mid_vld_r, out_vld_r;
  logic      out_adv, mid_adv, in_adv;

  // input register holds the raw item
  logic        cmd_r;
  logic [7:0]  report_hi_r;
  logic [7:0]  report_lo_r;
  logic [31:0] now_ms_r;

  gprd_mid_t   mid_dec;
  gprd_mid_t   mid_r;
  logic        turbo_a_on, turbo_b_on;
  logic [23:0] result_nxt;
  logic [23:0] result_r;

  assign out_adv   = !out_vld_r || out_tready;
  assign mid_adv   = !mid_vld_r || out_adv;
  assign in_adv    = !in_vld_r  || mid_adv;
  assign in_tready = in_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_adv)  in_vld_r  <= in_tvalid;
      if (mid_adv) mid_vld_r <= in_vld_r;
      if (out_adv) out_vld_r <= mid_vld_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_adv && in_tvalid) begin
      cmd_r       <= in_tuser;
      report_hi_r <= in_tdata[7:0];
      report_lo_r <= in_tdata[15:8];
      now_ms_r    <= in_tdata[47:16];
    end
    if (mid_adv && in_vld_r) begin
      mid_r <= mid_dec;
    end
    if (out_adv && mid_vld_r) begin
      result_r <= result_nxt;
    end
  end

  // decode stage: state only moves when the item passes on to the turbo stage
  gprd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (mid_adv && in_vld_r),
    .cmd       (cmd_r),
    .report_hi (report_hi_r),
    .report_lo (report_lo_r),
    .now_ms    (now_ms_r),
    .mid       (mid_dec)
  );

  // turbo stage: one reciprocal multiply per turbo key
  gprd_turbo u_turbo_a (
    .elapsed  (mid_r.elapsed_a),
    .phase_on (turbo_a_on)
  );

  gprd_turbo u_turbo_b (
    .elapsed  (mid_r.elapsed_b),
    .phase_on (turbo_b_on)
  );

  always_comb begin
    logic [7:0] game;
    game        = mid_r.game_base;
    game[BTN_A] = mid_r.game_base[BTN_A] || (mid_r.turbo_a_en && turbo_a_on);
    game[BTN_B] = mid_r.game_base[BTN_B] || (mid_r.turbo_b_en && turbo_b_on);
    result_nxt  = {3'b000, mid_r.rejected, mid_r.connected, mid_r.act, mid_r.nav, game};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = result_r;

endmodule
